[hdl/image_convolution_3x3_clamp_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution core
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONVOLUTION_3X3_CLAMP_CORE_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_CLAMP_CORE_ASSERT_SVH
`ifndef SYNTH
`define ICC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ICC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ICC_ASSERT_IMP(lbl, ante, cons, msg)
`define ICC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/icc_pkg.sv]
// ----------------------------------------------------------------------------
// icc_pkg
// Types and constants shared by the 3x3 convolution core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icc_pkg;

  localparam int KSize     = 3;
  localparam int PixW      = 8;
  localparam int CoefW     = 16;
  localparam int ProdW     = PixW + 1 + CoefW;   // unsigned pixel times signed Q8.8
  localparam int RowSumW   = ProdW + 2;          // three products
  localparam int SumW      = RowSumW + 2;        // three row sums
  localparam int FracW     = 8;
  localparam int RowW      = 12;
  localparam int ColOutW   = 10;
  localparam int WidthRegW = 11;
  localparam int HeightRegW = 12;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 48;

  localparam logic [PixW-1:0]       PixMax        = 8'd255;
  localparam logic [WidthRegW-1:0]  WidthReset    = 11'd1024;
  localparam logic [HeightRegW-1:0] HeightReset   = 12'd1024;
  localparam logic [CfgDataW-1:0]   KernelTopReset = 48'd0;
  localparam logic [CfgDataW-1:0]   KernelMidReset = 48'd16777216;
  localparam logic [CfgDataW-1:0]   KernelBotReset = 48'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth   = 3'd0,
    CfgHeight  = 3'd1,
    CfgKernTop = 3'd2,
    CfgKernMid = 3'd3,
    CfgKernBot = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_in;
    logic            frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0]    pixel_out;
    logic [RowW-1:0]    out_row;
    logic [ColOutW-1:0] out_col;
    logic               frame_end;
  } pix_out_t;

  // Window taps indexed [row][column], column 0 being the leftmost.
  typedef logic [KSize-1:0][KSize-1:0][PixW-1:0] taps_t;
  // One 48-bit packed coefficient row per kernel row.
  typedef logic [KSize-1:0][CfgDataW-1:0] kernel_t;

endpackage

[hdl/image_convolution_3x3_clamp_core.sv]
// ----------------------------------------------------------------------------
// image_convolution_3x3_clamp_core
// Streaming 3x3 convolution of 8-bit grey pixels, clamped to 0..255.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                          Transfer when
//  -------  -------------------------------  -------------------------------
//  input    in_valid_i in_ready_o in_data_i  in_valid_i and in_ready_o high
//  output   out_valid_o out_ready_i out_data_o  out_valid_o and out_ready_i high
//  config   cfg_we_i cfg_idx_i cfg_wdata_i   cfg_we_i high
//
//  One pixel is taken every cycle while the output is not stalled; the line
//  store has a read and a write port and is read and written once per pixel.
//  A result passes through the input, product, row-sum and output registers.
//  Reset clears position, window and pipeline; the line store is not cleared.
//  A stalled output fills the pipeline bubbles before the input is held off.
//
`timescale 1ns / 1ps

module image_convolution_3x3_clamp_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  icc_pkg::pix_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output icc_pkg::pix_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [icc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [icc_pkg::CfgDataW-1:0]        cfg_wdata_i
);

`include "image_convolution_3x3_clamp_core_assert.svh"

  // Column index width, and a compare width that holds the width register,
  // MAX_WIDTH and a column plus one.
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CmpW = (((XW + 1) > icc_pkg::WidthRegW) ? (XW + 1) : icc_pkg::WidthRegW) + 1;
  localparam int RW   = icc_pkg::RowW;
  localparam int PW   = icc_pkg::PixW;
  localparam int K    = icc_pkg::KSize;

  // Configuration registers.
  logic [icc_pkg::WidthRegW-1:0]  width_q;
  logic [icc_pkg::HeightRegW-1:0] height_q;
  icc_pkg::kernel_t               kernel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= icc_pkg::WidthReset;
      height_q    <= icc_pkg::HeightReset;
      kernel_q[0] <= icc_pkg::KernelTopReset;
      kernel_q[1] <= icc_pkg::KernelMidReset;
      kernel_q[2] <= icc_pkg::KernelBotReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        icc_pkg::CfgWidth:   width_q     <= cfg_wdata_i[icc_pkg::WidthRegW-1:0];
        icc_pkg::CfgHeight:  height_q    <= cfg_wdata_i[icc_pkg::HeightRegW-1:0];
        icc_pkg::CfgKernTop: kernel_q[0] <= cfg_wdata_i;
        icc_pkg::CfgKernMid: kernel_q[1] <= cfg_wdata_i;
        icc_pkg::CfgKernBot: kernel_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective image size: the width is held within 3..MAX_WIDTH and the
  // height is at least 3.
  logic [CmpW-1:0] eff_w;
  logic [RW:0]     eff_h;

  always_comb begin
    if (CmpW'(width_q) < CmpW'(3)) begin
      eff_w = CmpW'(3);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      eff_w = CmpW'(MAX_WIDTH);
    end else begin
      eff_w = CmpW'(width_q);
    end
    if (height_q < icc_pkg::HeightRegW'(3)) begin
      eff_h = (RW+1)'(3);
    end else begin
      eff_h = (RW+1)'(height_q);
    end
  end

  // Raster position of the next pixel.
  logic [XW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CmpW-1:0] cur_c, nxt_c;
  logic [RW:0]     cur_r, nxt_r;
  logic [XW-1:0]   cur_x;
  logic [RW-1:0]   cur_y;
  logic            accept;

  // The position is settled first: a frame start goes to the origin, and a
  // position left beyond a lowered width or height wraps to the next row or
  // to row zero. After the pixel the column advances and wraps likewise.
  always_comb begin
    cur_c = in_data_i.frame_start ? '0 : CmpW'(col_q);
    cur_r = in_data_i.frame_start ? '0 : (RW+1)'(row_q);
    if (cur_c >= eff_w) begin
      cur_c = '0;
      cur_r = cur_r + (RW+1)'(1);
    end
    if (cur_r >= eff_h) begin
      cur_r = '0;
    end
    cur_x = cur_c[XW-1:0];
    cur_y = cur_r[RW-1:0];

    nxt_c = CmpW'(cur_x) + CmpW'(1);
    nxt_r = (RW+1)'(cur_y) + (RW+1)'(1);
    if (nxt_c >= eff_w) begin
      col_d = '0;
      row_d = (nxt_r >= eff_h) ? '0 : nxt_r[RW-1:0];
    end else begin
      col_d = nxt_c[XW-1:0];
      row_d = cur_y;
    end
  end

  // Input register stage. It advances when it is empty or the arithmetic
  // pipeline can take its item; pixels off the interior pass through it too,
  // since they still shift the window and fill the line store.
  logic              s1_valid_q;
  logic [PW-1:0]     s1_pix_q;
  logic [XW-1:0]     s1_x_q;
  logic              s1_emit_q;
  icc_pkg::pix_out_t s1_meta_q;
  icc_pkg::pix_out_t meta_d;
  logic              pipe_ready;
  logic              en1;
  logic              s1_adv;
  logic [CmpW-1:0]   out_col_wide;

  assign en1        = !s1_valid_q || pipe_ready;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;
  assign s1_adv     = s1_valid_q && pipe_ready;

  always_comb begin
    out_col_wide     = CmpW'(cur_x) - CmpW'(1);
    meta_d.pixel_out = '0;
    meta_d.out_row   = cur_y - RW'(1);
    meta_d.out_col   = out_col_wide[icc_pkg::ColOutW-1:0];
    meta_d.frame_end = ((RW+1)'(cur_y) == (eff_h - (RW+1)'(1)))
                    && (CmpW'(cur_x) == (eff_w - CmpW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= in_data_i.pixel_in;
      s1_x_q    <= cur_x;
      s1_emit_q <= (cur_y >= RW'(2)) && (cur_x >= XW'(2));
      s1_meta_q <= meta_d;
    end
  end

  // Line store: each entry keeps the column from two rows up in the low byte
  // and from one row up in the high byte. It is read as a pixel is taken and
  // written back, shifted up by one row, as that pixel leaves the input stage.
  logic [2*PW-1:0] lb_rdata;
  logic [2*PW-1:0] lb_wdata;
  logic            lb_we;

  assign lb_we    = s1_adv;
  assign lb_wdata = {s1_pix_q, lb_rdata[2*PW-1:PW]};

  icc_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW),
    .DW    (2 * PW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (en1),
    .rd_addr_i (cur_x),
    .rd_data_o (lb_rdata),
    .wr_en_i   (lb_we),
    .wr_addr_i (s1_x_q),
    .wr_data_i (lb_wdata)
  );

  // Window of the two previous columns; the current column comes from the
  // line store and the incoming pixel.
  logic [K-1:0][K-2:0][PW-1:0] win_q;
  logic [K-1:0][PW-1:0]        new_col;
  icc_pkg::taps_t              taps;

  assign new_col[0] = lb_rdata[PW-1:0];
  assign new_col[1] = lb_rdata[2*PW-1:PW];
  assign new_col[2] = s1_pix_q;

  always_comb begin
    for (int r = 0; r < K; r++) begin
      taps[r][0] = win_q[r][0];
      taps[r][1] = win_q[r][1];
      taps[r][2] = new_col[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      for (int r = 0; r < K; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= new_col[r];
      end
    end
  end

  icc_conv_pipe u_conv_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && s1_emit_q),
    .in_ready_o  (pipe_ready),
    .taps_i      (taps),
    .kernel_i    (kernel_q),
    .meta_i      (s1_meta_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A frame start always places its pixel at column zero, off the interior.
  `ICC_ASSERT_NXT(a_frame_start_origin, accept && in_data_i.frame_start, (s1_x_q == '0) && !s1_emit_q, "frame start did not reset the position")
  // Every pixel taken lands inside the width in force when it was taken.
  `ICC_ASSERT_NXT(a_col_in_width, accept, CmpW'(s1_x_q) < $past(eff_w), "column beyond image width")
  // Back-to-back read and write of one entry happen only at column zero.
  `ICC_ASSERT_IMP(a_same_entry_col0, lb_we && accept && (s1_x_q == cur_x), cur_x == '0, "line store collision away from column zero")
  // Such a collision must hand the freshly written entry to the reader.
  `ICC_ASSERT_NXT(a_bypass_data, lb_we && en1 && (s1_x_q == cur_x), lb_rdata == $past(lb_wdata), "line store bypass returned stale data")

endmodule

[hdl/icc_line_buf.sv]
// ----------------------------------------------------------------------------
// icc_line_buf
// Two-row line store, one entry per column, with registered read and bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icc_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/icc_conv_pipe.sv]
// ----------------------------------------------------------------------------
// icc_conv_pipe
// Three-stage multiply, sum and clamp pipeline for one 3x3 window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icc_conv_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  icc_pkg::taps_t     taps_i,
  input  icc_pkg::kernel_t   kernel_i,
  input  icc_pkg::pix_out_t  meta_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icc_pkg::pix_out_t  out_data_o
);

  localparam int K = icc_pkg::KSize;

  logic signed [icc_pkg::ProdW-1:0]   prod_d [K][K];
  logic signed [icc_pkg::ProdW-1:0]   prod_q [K][K];
  logic signed [icc_pkg::RowSumW-1:0] rsum_d [K];
  logic signed [icc_pkg::RowSumW-1:0] rsum_q [K];
  logic signed [icc_pkg::SumW-1:0]    total;
  logic [icc_pkg::PixW-1:0]           clamped;

  icc_pkg::pix_out_t meta_a_q, meta_b_q, out_q;
  logic valid_a_q, valid_b_q, valid_c_q;
  logic en_a, en_b, en_c;

  // Each stage moves on when it is empty or its successor moves on.
  assign en_c       = !valid_c_q || out_ready_i;
  assign en_b       = !valid_b_q || en_c;
  assign en_a       = !valid_a_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K; c++) begin
        prod_d[r][c] = $signed({1'b0, taps_i[r][c]})
                     * $signed(kernel_i[r][icc_pkg::CoefW*c +: icc_pkg::CoefW]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < K; r++) begin
      rsum_d[r] = icc_pkg::RowSumW'(prod_q[r][0]) + icc_pkg::RowSumW'(prod_q[r][1])
                + icc_pkg::RowSumW'(prod_q[r][2]);
    end
  end

  // Negative sums give black; otherwise drop the fraction and saturate.
  always_comb begin
    total = icc_pkg::SumW'(rsum_q[0]) + icc_pkg::SumW'(rsum_q[1])
          + icc_pkg::SumW'(rsum_q[2]);
    if (total[icc_pkg::SumW-1]) begin
      clamped = '0;
    end else if (|total[icc_pkg::SumW-2:icc_pkg::FracW+icc_pkg::PixW]) begin
      clamped = icc_pkg::PixMax;
    end else begin
      clamped = total[icc_pkg::FracW +: icc_pkg::PixW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (en_a) valid_a_q <= in_valid_i;
      if (en_b) valid_b_q <= valid_a_q;
      if (en_c) valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      prod_q   <= prod_d;
      meta_a_q <= meta_i;
    end
    if (en_b) begin
      rsum_q   <= rsum_d;
      meta_b_q <= meta_a_q;
    end
    if (en_c) begin
      out_q           <= meta_b_q;
      out_q.pixel_out <= clamped;
    end
  end

  assign out_valid_o = valid_c_q;
  assign out_data_o  = out_q;

endmodule
